// ===== rtl/vsc_pkg.sv =====
// ----------------------------------------------------------------------------
// vsc_pkg
// Types, codes and helpers for the scalar coercion unit.
// ----------------------------------------------------------------------------
package vsc_pkg;

  typedef enum logic [1:0] {
    OP_INT   = 2'd0,
    OP_FLOAT = 2'd1,
    OP_BOOL  = 2'd2,
    OP_RSVD  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    KIND_NIL   = 3'd0,
    KIND_BOOL  = 3'd1,
    KIND_INT   = 3'd2,
    KIND_DBL   = 3'd3,
    KIND_OTHER = 3'd4,
    KIND_X5    = 3'd5,
    KIND_X6    = 3'd6,
    KIND_X7    = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_INVALID = 2'd2,
    ST_RSVD    = 2'd3
  } status_e;

  localparam logic [63:0] DBL_ONE = 64'h3FF0_0000_0000_0000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  kind;
    logic [63:0] payload;
  } vsc_in_t;

  typedef struct packed {
    logic [63:0] result_bits;
    logic        inexact;
    logic [1:0]  status;
  } vsc_out_t;

  // Decoded item after stage 1.
  typedef enum logic [2:0] {
    PATH_CONST = 3'd0,
    PATH_D2I   = 3'd1,
    PATH_I2D   = 3'd2,
    PATH_PASS  = 3'd3,
    PATH_ERR   = 3'd4
  } path_e;

  typedef struct packed {
    path_e       path;
    logic        sign;
    logic [10:0] expo;
    logic [63:0] mag;     // |int| or mantissa with hidden bit at [52]
    logic [63:0] bits;    // constant or passthrough result
    status_e     status;
  } s1_t;

  // After normalization / shift stage.
  typedef struct packed {
    path_e       path;
    logic        sign;
    logic [63:0] mag;     // shifted integer or normalized magnitude
    logic        sticky;  // fraction lost in the d2i shift; not set for i2d
    logic [6:0]  lz;
    logic        zero;
    logic [63:0] bits;
    status_e     status;
  } s2_t;

  function automatic logic [6:0] lzc64(input logic [63:0] v);
    logic [6:0] n;
    logic       found;
    n = 7'd64;
    found = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 7'(63 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

// ===== rtl/variant_scalar_coercion_unit.sv =====
// ----------------------------------------------------------------------------
// variant_scalar_coercion_unit
// Converts a tagged scalar to int64, double or bool.
// ----------------------------------------------------------------------------
// channel | ports                    | transfer
// in      | start_i, busy_o, in_i    | start_i && !busy_o
// out     | done_o, out_o            | done_o (one cycle, no stall)
//
// Three register stages: decode, shift/normalize, round/pack.
// One item per cycle; busy_o is always low.
// Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module variant_scalar_coercion_unit import vsc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  vsc_in_t  in_i,
  output logic     done_o,
  output vsc_out_t out_o
);

  logic v1, v2;
  s1_t  s1;
  s2_t  s2;

  assign busy_o = 1'b0;

  vsc_decode u_dec (
    .clk_i, .rst_ni, .vld_i(start_i && !busy_o), .in_i, .vld_o(v1), .s1_o(s1)
  );
  vsc_shift u_sh (
    .clk_i, .rst_ni, .vld_i(v1), .s1_i(s1), .vld_o(v2), .s2_o(s2)
  );
  vsc_pack u_pk (
    .clk_i, .rst_ni, .vld_i(v2), .s2_i(s2), .vld_o(done_o), .out_o
  );

endmodule

// ===== rtl/vsc_decode.sv =====
// ----------------------------------------------------------------------------
// vsc_decode
// Stage 1: classifies the operand, catches errors and trivial results.
// ----------------------------------------------------------------------------
module vsc_decode import vsc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    vld_i,
  input  vsc_in_t in_i,
  output logic    vld_o,
  output s1_t     s1_o
);

  s1_t  s1_d, s1_q;
  logic vld_q;
  logic [10:0] e;
  logic        nan, dzero;

  always_comb begin
    e     = in_i.payload[62:52];
    nan   = (e == 11'h7FF) && (in_i.payload[51:0] != '0);
    dzero = (in_i.payload[62:0] == '0);
    s1_d        = '0;
    s1_d.path   = PATH_ERR;
    s1_d.status = ST_INVALID;
    s1_d.sign   = in_i.payload[63];
    s1_d.expo   = e;
    unique case (opcode_e'(in_i.opcode))
      OP_INT: begin
        unique case (kind_e'(in_i.kind))
          KIND_BOOL: begin
            s1_d.path = PATH_CONST; s1_d.status = ST_OK;
            s1_d.bits = {63'd0, in_i.payload[0]};
          end
          KIND_INT: begin
            s1_d.path = PATH_PASS; s1_d.status = ST_OK;
            s1_d.bits = in_i.payload;
          end
          KIND_DBL: begin
            if (e == 11'h7FF || nan) begin
              s1_d.status = ST_RANGE;
            end else if (e >= 11'd1086 && !(in_i.payload[63] && e == 11'd1086 &&
                         in_i.payload[51:0] == '0)) begin
              s1_d.status = ST_RANGE;
            end else begin
              s1_d.path   = PATH_D2I;
              s1_d.status = ST_OK;
              s1_d.mag    = {11'd0, (e != 11'd0), in_i.payload[51:0]};
            end
          end
          default: ;
        endcase
      end
      OP_FLOAT: begin
        unique case (kind_e'(in_i.kind))
          KIND_BOOL: begin
            s1_d.path = PATH_CONST; s1_d.status = ST_OK;
            s1_d.bits = in_i.payload[0] ? DBL_ONE : 64'd0;
          end
          KIND_DBL: begin
            s1_d.path = PATH_PASS; s1_d.status = ST_OK;
            s1_d.bits = in_i.payload;
          end
          KIND_INT: begin
            s1_d.path   = PATH_I2D;
            s1_d.status = ST_OK;
            s1_d.mag    = in_i.payload[63] ? (~in_i.payload + 64'd1) : in_i.payload;
          end
          default: ;
        endcase
      end
      OP_BOOL: begin
        unique case (kind_e'(in_i.kind))
          KIND_NIL: begin
            s1_d.path = PATH_CONST; s1_d.status = ST_OK;
          end
          KIND_BOOL: begin
            s1_d.path = PATH_CONST; s1_d.status = ST_OK;
            s1_d.bits = {63'd0, in_i.payload[0]};
          end
          KIND_INT: begin
            s1_d.path = PATH_CONST; s1_d.status = ST_OK;
            s1_d.bits = {63'd0, in_i.payload != '0};
          end
          KIND_DBL: begin
            s1_d.path = PATH_CONST; s1_d.status = ST_OK;
            s1_d.bits = {63'd0, !dzero};
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  assign vld_o = vld_q;
  assign s1_o  = s1_q;

endmodule

// ===== rtl/vsc_shift.sv =====
// ----------------------------------------------------------------------------
// vsc_shift
// Stage 2: aligns the double mantissa to an integer, or counts leading zeros
// of the integer magnitude and shifts it left by that count to normalize it.
// ----------------------------------------------------------------------------
module vsc_shift import vsc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic vld_i,
  input  s1_t  s1_i,
  output logic vld_o,
  output s2_t  s2_o
);

  s2_t  s2_d, s2_q;
  logic vld_q;
  logic [116:0] wide;
  logic [6:0]   lz;
  logic [11:0]  sh;

  always_comb begin
    s2_d        = '0;
    s2_d.path   = s1_i.path;
    s2_d.sign   = s1_i.sign;
    s2_d.bits   = s1_i.bits;
    s2_d.status = s1_i.status;
    wide = '0;
    sh   = '0;
    lz   = lzc64(s1_i.mag);
    if (s1_i.path == PATH_D2I) begin
      // value = mag * 2^(e-1075), e=0 treated as subnormal (always < 1)
      if (s1_i.expo >= 11'd1075) begin
        sh = 12'(s1_i.expo) - 12'd1075;
        s2_d.mag = s1_i.mag << sh[5:0];
      end else begin
        sh = 12'd1075 - 12'(s1_i.expo);
        // mantissa fits in 53 bits, so a 53-bit shift already clears it
        if (sh > 12'd53) sh = 12'd53;
        wide = {s1_i.mag, 53'd0} >> sh[6:0];
        s2_d.mag    = wide[116:53];
        s2_d.sticky = (wide[52:0] != '0);
      end
    end else begin
      s2_d.mag  = s1_i.mag << lz[5:0];
      s2_d.lz   = lz;
      s2_d.zero = (s1_i.mag == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_q <= s2_d;
  end

  assign vld_o = vld_q;
  assign s2_o  = s2_q;

endmodule

// ===== rtl/vsc_pack.sv =====
// ----------------------------------------------------------------------------
// vsc_pack
// Stage 3: negation, rounding and result assembly.
// ----------------------------------------------------------------------------
module vsc_pack import vsc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     vld_i,
  input  s2_t      s2_i,
  output logic     vld_o,
  output vsc_out_t out_o
);

  vsc_out_t out_d, out_q;
  logic     vld_q;
  logic [53:0] rm;
  logic        lsb, grd, stk, up;
  logic [10:0] ex;

  always_comb begin
    out_d = '0;
    lsb = s2_i.mag[11];
    grd = s2_i.mag[10];
    stk = (s2_i.mag[9:0] != '0);
    up  = grd && (stk || lsb);
    rm  = {1'b0, s2_i.mag[63:11]} + {53'd0, up};
    ex  = 11'd1086 - 11'(s2_i.lz) + 11'(rm[53]);
    unique case (s2_i.path)
      PATH_CONST, PATH_PASS: begin
        out_d.result_bits = s2_i.bits;
      end
      PATH_D2I: begin
        out_d.result_bits = s2_i.sign ? (~s2_i.mag + 64'd1) : s2_i.mag;
        out_d.inexact     = s2_i.sticky;
      end
      PATH_I2D: begin
        if (!s2_i.zero) begin
          out_d.result_bits = {s2_i.sign, ex, rm[53] ? rm[52:1] : rm[51:0]};
          out_d.inexact     = grd || stk || (!s2_i.sign && ex == 11'd1086);
        end
      end
      default: ;
    endcase
    out_d.status = s2_i.status;
    if (s2_i.status != ST_OK) begin
      out_d.result_bits = '0;
      out_d.inexact     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign vld_o = vld_q;
  assign out_o = out_q;

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_o && out_o.status != ST_OK |-> out_o.result_bits == '0 && !out_o.inexact)
    else $error("error result carries data");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_o |-> out_o.status != ST_RSVD)
    else $error("reserved status");
  a_vld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_i |=> vld_o)
    else $error("item dropped in last stage");

endmodule
